>>> hdl/kpte_pkg.sv
// Shared types and constants for the keypad timer field entry block.
// No dependencies; kpte_ctrl and the top level in hdl/ import this package.
package kpte_pkg;

  localparam int unsigned MAX_FIELDS_DEF = 8;
  localparam int unsigned VAL_W          = 7;

  localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [3:0] KEY_A         = 4'd10;
  localparam logic [3:0] KEY_B         = 4'd11;
  localparam logic [3:0] KEY_D         = 4'd13;
  localparam logic [3:0] KEY_STAR      = 4'd14;
  localparam logic [3:0] KEY_HASH      = 4'd15;

  localparam logic [VAL_W-1:0] HOUR_MAX   = 7'd23;
  localparam logic [VAL_W-1:0] MINSEC_MAX = 7'd59;
  localparam logic [VAL_W-1:0] DIGIT_BASE = 7'd10;

  typedef enum logic [2:0] {
    MODE_STANDBY = 3'd0,
    MODE_MANUAL  = 3'd1,
    MODE_SELECT  = 3'd2,
    MODE_DAYS    = 3'd3,
    MODE_HOURS   = 3'd4,
    MODE_MINUTES = 3'd5,
    MODE_SECONDS = 3'd6,
    MODE_RUN     = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    PH_NONE   = 3'd0,
    PH_FIRST  = 3'd1,
    PH_TENS   = 3'd2,
    PH_SECOND = 3'd3,
    PH_ONES   = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_NEIGH,
    ST_OUT
  } state_e;

  typedef struct packed {
    mode_e            mode;
    phase_e           phase;
    logic [VAL_W-1:0] days;
    logic [VAL_W-1:0] hours;
    logic [VAL_W-1:0] minutes;
    logic [VAL_W-1:0] seconds;
    logic             blink;
    logic             run;
    logic             error;
    logic             done;
    logic             pending;
    logic             shown;
  } res_t;

endpackage

>>> hdl/kpte_list_mem.sv
// Field list store: one write port, one read port with registered data.
// Depends on nothing; address width is handed down from the top level.
module kpte_list_mem #(
  parameter int unsigned AW = 3
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [1:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [1:0]    rdata_o
);

  logic [1:0] mem_q [2**AW];
  logic [1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/kpte_ctrl.sv
// Entry sequencer: mode, phase, field values, flags and the list scan.
// Depends on kpte_pkg; drives the field list store through its ports.
module kpte_ctrl #(
  parameter int unsigned MAX_FIELDS = kpte_pkg::MAX_FIELDS_DEF,
  parameter int unsigned AW         = 3,
  parameter int unsigned CW         = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          req_type_i,
  input  logic [3:0]    key_code_i,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [1:0]    mem_wdata_o,
  output logic [AW-1:0] mem_raddr_o,
  input  logic [1:0]    mem_rdata_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output kpte_pkg::res_t res_o
);
  import kpte_pkg::*;

  state_e           state_q, state_d;
  mode_e            mode_q, mode_d;
  phase_e           phase_q, phase_d;
  logic [VAL_W-1:0] vals_q [4];
  logic [VAL_W-1:0] vals_d [4];
  logic [3:0]       held_q, held_d;
  logic [CW-1:0]    len_q, len_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             err_q, err_d;
  logic             done_q, done_d;
  logic             pend_q, pend_d;
  logic             shown_q, shown_d;
  logic             blink_q, blink_d;
  logic             run_q, run_d;
  logic             fwd_q, fwd_d;

  logic [2:0]       mode_off;
  logic [1:0]       fsel;
  logic             digit;
  logic             ok;
  logic [CW-1:0]    idx_inc;
  logic [CW-1:0]    idx_dec;
  logic [CW-1:0]    len_inc;
  logic [2:0]       key_off;

  assign mode_off = 3'(mode_q) - 3'(MODE_DAYS);
  assign fsel     = mode_off[1:0];
  assign digit    = key_code_i <= KEY_DIGIT_MAX;
  assign idx_inc  = idx_q + CW'(1);
  assign idx_dec  = idx_q - CW'(1);
  assign len_inc  = len_q + CW'(1);
  assign key_off  = 3'(key_code_i - KEY_A);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      mode_q  <= MODE_STANDBY;
      phase_q <= PH_NONE;
      for (int i = 0; i < 4; i++) begin
        vals_q[i] <= '0;
      end
      held_q  <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      err_q   <= 1'b0;
      done_q  <= 1'b0;
      pend_q  <= 1'b0;
      shown_q <= 1'b0;
      blink_q <= 1'b0;
      run_q   <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      phase_q <= phase_d;
      for (int i = 0; i < 4; i++) begin
        vals_q[i] <= vals_d[i];
      end
      held_q  <= held_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      err_q   <= err_d;
      done_q  <= done_d;
      pend_q  <= pend_d;
      shown_q <= shown_d;
      blink_q <= blink_d;
      run_q   <= run_d;
      fwd_q   <= fwd_d;
    end
  end

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    phase_d = phase_q;
    for (int i = 0; i < 4; i++) begin
      vals_d[i] = vals_q[i];
    end
    held_d  = held_q;
    len_d   = len_q;
    idx_d   = idx_q;
    err_d   = err_q;
    done_d  = done_q;
    pend_d  = pend_q;
    shown_d = shown_q;
    blink_d = blink_q;
    run_d   = run_q;
    fwd_d   = fwd_q;
    ok      = 1'b1;

    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = len_q[AW-1:0];
    mem_wdata_o = key_off[1:0];
    mem_raddr_o = '0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          blink_d = 1'b0;
          run_d   = 1'b0;
          state_d = ST_OUT;
          if (req_type_i) begin
            len_d   = '0;
            mode_d  = MODE_SELECT;
            phase_d = PH_NONE;
            done_d  = 1'b0;
          end else if (mode_q == MODE_SELECT) begin
            if (key_code_i == KEY_HASH) begin
              done_d = 1'b1;
              if (len_q != '0) begin
                phase_d = PH_NONE;
                state_d = ST_NEIGH;
              end else begin
                mode_d = MODE_STANDBY;
              end
            end else if (key_code_i >= KEY_A && key_code_i <= KEY_D) begin
              if (len_q < CW'(MAX_FIELDS)) begin
                mem_we_o = 1'b1;
                len_d    = len_inc;
              end
            end
          end else if (mode_q >= MODE_DAYS && mode_q <= MODE_SECONDS) begin
            unique case (phase_q)
              PH_NONE: begin
                if (digit) begin
                  phase_d = PH_FIRST;
                  blink_d = 1'b1;
                  held_d  = key_code_i;
                  pend_d  = 1'b1;
                end else if (key_code_i == KEY_B) begin
                  fwd_d   = 1'b0;
                  idx_d   = '0;
                  state_d = ST_SCAN;
                end
              end
              PH_FIRST: begin
                if (key_code_i == KEY_STAR) begin
                  phase_d      = PH_TENS;
                  vals_d[fsel] = {3'b000, held_q} * DIGIT_BASE;
                  pend_d       = 1'b0;
                end else if (key_code_i == KEY_B) begin
                  phase_d = PH_NONE;
                end
              end
              PH_TENS: begin
                if (digit) begin
                  phase_d = PH_SECOND;
                  blink_d = 1'b1;
                  held_d  = key_code_i;
                end else if (key_code_i == KEY_B) begin
                  phase_d = PH_NONE;
                end
              end
              PH_SECOND: begin
                if (key_code_i == KEY_STAR) begin
                  phase_d      = PH_ONES;
                  vals_d[fsel] = vals_q[fsel] + {3'b000, held_q};
                end else if (key_code_i == KEY_B) begin
                  phase_d = PH_NONE;
                end
              end
              default: begin
                phase_d = PH_NONE;
                if (key_code_i == KEY_D) begin
                  shown_d = 1'b1;
                  blink_d = 1'b1;
                  if (mode_q == MODE_HOURS) begin
                    if (vals_q[1] > HOUR_MAX) begin
                      vals_d[1] = '0;
                      ok        = 1'b0;
                    end
                  end else if (mode_q > MODE_HOURS) begin
                    if (vals_q[fsel] > MINSEC_MAX) begin
                      ok = 1'b0;
                    end
                  end
                  if (ok) begin
                    fwd_d   = 1'b1;
                    idx_d   = '0;
                    state_d = ST_SCAN;
                  end else begin
                    err_d = 1'b1;
                  end
                end else if (key_code_i != KEY_B) begin
                  phase_d = PH_ONES;
                end
              end
            endcase
          end
        end
      end
      ST_SCAN: begin
        if (idx_q >= len_q) begin
          mode_d  = MODE_STANDBY;
          state_d = ST_OUT;
        end else if (mem_rdata_i == fsel) begin
          if (fwd_q) begin
            if (idx_inc < len_q) begin
              mem_raddr_o = idx_inc[AW-1:0];
              state_d     = ST_NEIGH;
            end else begin
              mode_d  = MODE_RUN;
              len_d   = '0;
              run_d   = 1'b1;
              state_d = ST_OUT;
            end
          end else begin
            if (idx_q != '0) begin
              mem_raddr_o = idx_dec[AW-1:0];
              state_d     = ST_NEIGH;
            end else begin
              mode_d  = MODE_MANUAL;
              len_d   = '0;
              state_d = ST_OUT;
            end
          end
        end else begin
          idx_d       = idx_inc;
          mem_raddr_o = idx_inc[AW-1:0];
        end
      end
      ST_NEIGH: begin
        mode_d  = mode_e'(3'(MODE_DAYS) + {1'b0, mem_rdata_i});
        state_d = ST_OUT;
      end
      default: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    res_o.mode    = mode_q;
    res_o.phase   = phase_q;
    res_o.days    = vals_q[0];
    res_o.hours   = vals_q[1];
    res_o.minutes = vals_q[2];
    res_o.seconds = vals_q[3];
    res_o.blink   = blink_q;
    res_o.run     = run_q;
    res_o.error   = err_q;
    res_o.done    = done_q;
    res_o.pending = pend_q;
    res_o.shown   = shown_q;
  end

endmodule

>>> hdl/keypad_timer_field_entry_top.sv
// Top level of the keypad timer field entry block: sequencer, field list
// store and result register. Depends on kpte_pkg, kpte_ctrl, kpte_list_mem.
//
//   channel | handshake               | payload
//   --------+-------------------------+----------------------------------------
//   input   | in_valid_i / in_ready_o | req_type_i, key_code_i
//   result  | out_valid_o/out_ready_i | mode_o, entry_phase_o, *_value_o, flags
//
// Most transfers pass the sequencer's ST_OUT state on the way to the result
// register; the sequencer takes no new input while it still holds a result.
// 'B' with no digit typed and a good 'D' scan the field list one entry a cycle
// through the single read port; a match may then read the neighbour entry in
// ST_NEIGH before ST_OUT hands the result on.
// Reset clears mode, phase, values and flags; the list store is not cleared.
// A waiting result does not block the next input transfer; the following
// result waits in the sequencer until the result register frees up.
module keypad_timer_field_entry_top #(
  parameter int unsigned MAX_FIELDS = kpte_pkg::MAX_FIELDS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       req_type_i,
  input  logic [3:0] key_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] mode_o,
  output logic [2:0] entry_phase_o,
  output logic [6:0] days_value_o,
  output logic [6:0] hours_value_o,
  output logic [6:0] minutes_value_o,
  output logic [6:0] seconds_value_o,
  output logic       blink_start_o,
  output logic       run_start_o,
  output logic       entry_error_o,
  output logic       list_done_o,
  output logic       first_digit_pending_o,
  output logic       value_shown_o
);
  import kpte_pkg::*;

  localparam int unsigned AW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int unsigned CW = $clog2(MAX_FIELDS + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [1:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [1:0]    mem_rdata;
  logic          res_valid;
  logic          res_ready;
  res_t          res;
  res_t          res_q;
  logic          out_valid_q;

  kpte_ctrl #(
    .MAX_FIELDS(MAX_FIELDS),
    .AW        (AW),
    .CW        (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .req_type_i (req_type_i),
    .key_code_i (key_code_i),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  kpte_list_mem #(
    .AW(AW)
  ) u_list_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      res_q <= res;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign mode_o                = 3'(res_q.mode);
  assign entry_phase_o         = 3'(res_q.phase);
  assign days_value_o          = res_q.days;
  assign hours_value_o         = res_q.hours;
  assign minutes_value_o       = res_q.minutes;
  assign seconds_value_o       = res_q.seconds;
  assign blink_start_o         = res_q.blink;
  assign run_start_o           = res_q.run;
  assign entry_error_o         = res_q.error;
  assign list_done_o           = res_q.done;
  assign first_digit_pending_o = res_q.pending;
  assign value_shown_o         = res_q.shown;

endmodule
